// ===== hdl/f32ln_pkg.sv =====
package f32ln_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] NEG_INF   = 32'hFF80_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;
  localparam logic [31:0] MINUS_ONE = 32'hBF80_0000;
  localparam logic [31:0] LN2_BITS  = 32'h3F31_7218;
  localparam logic [7:0]  EXP_ONES  = 8'hFF;
  localparam logic [7:0]  EXP_BIAS  = 8'd127;

  // Reciprocals of the odd numbers 1 to 79 for the series that fills the ln table.
  localparam real ODD_RECIP [40] = '{
    1.0/1.0,  1.0/3.0,  1.0/5.0,  1.0/7.0,  1.0/9.0,  1.0/11.0, 1.0/13.0, 1.0/15.0,
    1.0/17.0, 1.0/19.0, 1.0/21.0, 1.0/23.0, 1.0/25.0, 1.0/27.0, 1.0/29.0, 1.0/31.0,
    1.0/33.0, 1.0/35.0, 1.0/37.0, 1.0/39.0, 1.0/41.0, 1.0/43.0, 1.0/45.0, 1.0/47.0,
    1.0/49.0, 1.0/51.0, 1.0/53.0, 1.0/55.0, 1.0/57.0, 1.0/59.0, 1.0/61.0, 1.0/63.0,
    1.0/65.0, 1.0/67.0, 1.0/69.0, 1.0/71.0, 1.0/73.0, 1.0/75.0, 1.0/77.0, 1.0/79.0
  };

  // Item after classification and normalization.
  typedef struct packed {
    logic              last;
    logic              spec;
    logic [31:0]       spec_bits;
    logic signed [8:0] e;
    logic [22:0]       mant;
  } front_t;

  // Operands of the two products and the table log.
  typedef struct packed {
    logic        last;
    logic        spec;
    logic [31:0] spec_bits;
    logic [31:0] m;
    logic [31:0] inv;
    logic [31:0] ef;
    logic [31:0] lnv;
  } opnd_t;

  // Unrounded product.
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [9:0]  exp;
    logic [47:0] prod;
  } mraw_t;

  // Rounded products and the table log, ready for the adders.
  typedef struct packed {
    logic        last;
    logic        spec;
    logic [31:0] spec_bits;
    logic [31:0] prod;
    logic [31:0] ep;
    logic [31:0] lnv;
  } prod_t;

  function automatic logic [31:0] real_to_f32(real v);
    logic [63:0] b;
    logic [10:0] fe;
    logic [23:0] man;
    logic        rnd;
    b   = $realtobits(v);
    fe  = b[62:52] - 11'd1023 + 11'd127;
    rnd = b[28] & ((|b[27:0]) | b[29]);
    man = {1'b0, b[51:29]} + {23'd0, rnd};
    fe  = fe + {10'd0, man[23]};
    return {b[63], fe[7:0], man[22:0]};
  endfunction

  // 2*atanh(s), where s = (c - 1) / (c + 1) for the bin center c.
  function automatic real ln_series(real s);
    real s2;
    real term;
    real sum;
    s2   = s * s;
    term = s;
    sum  = 0.0;
    for (int i = 0; i < 40; i++) begin
      sum  = sum + term * ODD_RECIP[i];
      term = term * s2;
    end
    return 2.0 * sum;
  endfunction

  // Exact conversion of a small signed exponent to binary32.
  function automatic logic [31:0] int_to_f32(logic signed [8:0] e);
    logic       neg;
    logic [8:0] mag;
    logic [2:0] p;
    logic [23:0] m24;
    neg = e[8];
    mag = neg ? 9'(-e) : e;
    p   = '0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) p = 3'(i);
    end
    m24 = {16'd0, mag[7:0]} << (5'd23 - {2'b0, p});
    if (mag == '0) return '0;
    return {neg, EXP_BIAS + {5'd0, p}, m24[22:0]};
  endfunction

  function automatic mraw_t fmul_raw(logic [31:0] a, logic [31:0] b);
    mraw_t r;
    r.sign = a[31] ^ b[31];
    r.zero = (a[30:0] == '0) || (b[30:0] == '0);
    r.exp  = {2'b0, a[30:23]} + {2'b0, b[30:23]};
    r.prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] fmul_round(mraw_t r);
    logic [22:0] man;
    logic        g;
    logic        st;
    logic [23:0] rm;
    logic [9:0]  ex;
    if (r.prod[47]) begin
      man = r.prod[46:24];
      g   = r.prod[23];
      st  = |r.prod[22:0];
      ex  = r.exp - 10'd126;
    end else begin
      man = r.prod[45:23];
      g   = r.prod[22];
      st  = |r.prod[21:0];
      ex  = r.exp - 10'd127;
    end
    rm = {1'b0, man} + {23'd0, g & (st | man[0])};
    ex = ex + {9'd0, rm[23]};
    if (r.zero) return {r.sign, 31'd0};
    return {r.sign, ex[7:0], rm[22:0]};
  endfunction

  // Round-to-nearest-even add for normal or zero operands.
  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] sh;
    logic        sticky;
    logic [7:0]  d;
    logic [27:0] s;
    logic [26:0] n;
    logic [4:0]  lz;
    logic        found;
    logic [9:0]  ex;
    logic [24:0] rm;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    if (x[30:0] == '0) return {a[31] & b[31], 31'd0};
    mx = {1'b1, x[22:0], 3'b000};
    my = (y[30:0] == '0) ? '0 : {1'b1, y[22:0], 3'b000};
    d  = x[30:23] - y[30:23];
    if (d >= 8'd27) begin
      sh     = '0;
      sticky = |my;
    end else begin
      sh     = my >> d;
      sticky = |(my & ~(27'h7FF_FFFF << d));
    end
    sh[0] = sh[0] | sticky;
    if (x[31] == y[31]) s = {1'b0, mx} + {1'b0, sh};
    else                s = {1'b0, mx} - {1'b0, sh};
    if (s == '0) return '0;
    ex = {2'b0, x[30:23]};
    if (s[27]) begin
      n  = {s[27:2], s[1] | s[0]};
      ex = ex + 10'd1;
    end else begin
      lz    = '0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && s[i]) begin
          lz    = 5'(26 - i);
          found = 1'b1;
        end
      end
      n  = s[26:0] << lz;
      ex = ex - {5'd0, lz};
    end
    rm = {1'b0, n[26:3]} + {24'd0, n[2] & (n[1] | n[0] | n[3])};
    ex = ex + {9'd0, rm[24]};
    return {x[31], ex[7:0], rm[24] ? rm[23:1] : rm[22:0]};
  endfunction

endpackage

// ===== hdl/f32ln_front.sv =====
module f32ln_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [31:0]     value_bits,
  input  logic            is_last,
  output logic            valid,
  output f32ln_pkg::front_t q
);
  import f32ln_pkg::*;

  front_t     d;
  logic [7:0] expf;
  logic [22:0] frac;
  logic [4:0] lz;
  logic       found;

  always_comb begin
    expf = value_bits[30:23];
    frac = value_bits[22:0];
    lz   = '0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && frac[i]) begin
        lz    = 5'(22 - i);
        found = 1'b1;
      end
    end
    d.last      = is_last;
    d.spec      = 1'b1;
    d.spec_bits = CANON_NAN;
    if (expf == EXP_ONES) begin
      d.spec_bits = (frac != '0) ? value_bits : (value_bits[31] ? CANON_NAN : POS_INF);
    end else if (value_bits[30:0] == '0) begin
      d.spec_bits = NEG_INF;
    end else if (!value_bits[31]) begin
      d.spec = 1'b0;
    end
    if (expf == '0) begin
      // Subnormal: normalize, which also folds in the 2^23 scaling.
      d.e    = -9'sd127 - $signed({4'd0, lz});
      d.mant = frac << (lz + 5'd1);
    end else begin
      d.e    = $signed({1'b0, expf}) - 9'sd127;
      d.mant = frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= d;
    end
  end
endmodule

// ===== hdl/f32ln_table.sv =====
module f32ln_table #(
  parameter int TABLE_INDEX_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  f32ln_pkg::front_t  din,
  output logic               valid,
  output f32ln_pkg::opnd_t   q
);
  import f32ln_pkg::*;

  localparam int TableSize = 1 << TABLE_INDEX_BITS;

  logic [31:0] ln_rom  [TableSize];
  logic [31:0] inv_rom [TableSize];
  logic [TABLE_INDEX_BITS-1:0] idx;

  for (genvar k = 0; k < TableSize; k++) begin : g_rom
    localparam real Center = 1.0 + (real'(k) + 0.5) / real'(TableSize);
    localparam real Ratio  = (Center - 1.0) / (Center + 1.0);
    localparam logic [31:0] LnBits  = real_to_f32(ln_series(Ratio));
    localparam logic [31:0] InvBits = real_to_f32(1.0 / Center);
    assign ln_rom[k]  = LnBits;
    assign inv_rom[k] = InvBits;
  end

  assign idx = din.mant[22 -: TABLE_INDEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q.last      <= din.last;
      q.spec      <= din.spec;
      q.spec_bits <= din.spec_bits;
      q.m         <= {1'b0, EXP_BIAS, din.mant};
      q.inv       <= inv_rom[idx];
      q.lnv       <= ln_rom[idx];
      q.ef        <= int_to_f32(din.e);
    end
  end
endmodule

// ===== hdl/f32ln_mul.sv =====
module f32ln_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  f32ln_pkg::opnd_t  din,
  output logic              valid,
  output f32ln_pkg::prod_t  q
);
  import f32ln_pkg::*;

  logic        raw_valid;
  mraw_t       raw_m;
  mraw_t       raw_e;
  logic        raw_last;
  logic        raw_spec;
  logic [31:0] raw_spec_bits;
  logic [31:0] raw_lnv;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
      valid     <= 1'b0;
    end else if (adv) begin
      raw_valid <= in_valid;
      valid     <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_m         <= fmul_raw(din.m, din.inv);
      raw_e         <= fmul_raw(din.ef, LN2_BITS);
      raw_last      <= din.last;
      raw_spec      <= din.spec;
      raw_spec_bits <= din.spec_bits;
      raw_lnv       <= din.lnv;
      q.last        <= raw_last;
      q.spec        <= raw_spec;
      q.spec_bits   <= raw_spec_bits;
      q.lnv         <= raw_lnv;
      q.prod        <= fmul_round(raw_m);
      q.ep          <= fmul_round(raw_e);
    end
  end
endmodule

// ===== hdl/f32ln_add.sv =====
module f32ln_add (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  f32ln_pkg::prod_t  din,
  output logic              valid,
  output logic [31:0]       log_bits,
  output logic              end_of_array
);
  import f32ln_pkg::*;

  logic        mid_valid;
  logic [31:0] mid_r;
  logic [31:0] mid_acc;
  logic        mid_last;
  logic        mid_spec;
  logic [31:0] mid_spec_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      valid     <= 1'b0;
    end else if (adv) begin
      mid_valid <= in_valid;
      valid     <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r         <= fadd(din.prod, MINUS_ONE);
      mid_acc       <= fadd(din.ep, din.lnv);
      mid_last      <= din.last;
      mid_spec      <= din.spec;
      mid_spec_bits <= din.spec_bits;
      log_bits      <= mid_spec ? mid_spec_bits : fadd(mid_acc, mid_r);
      end_of_array  <= mid_last;
    end
  end
endmodule

// ===== hdl/float32_log_lut_approx.sv =====
// Approximate natural log of a binary32 word. One value is taken every clock
// cycle and its result passes through six register stages, which are
// classification with subnormal normalization, the ln and 1/m table read, two
// product stages, and two add stages. The whole pipeline stalls together
// while a finished result is not taken, so throughput is one transfer a cycle
// whenever the output side keeps log_ready high.
module float32_log_lut_approx #(
  parameter int TABLE_INDEX_BITS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        value_valid,
  output logic        value_ready,
  input  logic [31:0] value_bits,
  input  logic        is_last,
  output logic        log_valid,
  input  logic        log_ready,
  output logic [31:0] log_bits,
  output logic        end_of_array
);
  import f32ln_pkg::*;

  logic    adv;
  logic    v1;
  logic    v2;
  logic    v3;
  front_t  s1;
  opnd_t   s2;
  prod_t   s3;

  assign adv         = log_ready || !log_valid;
  assign value_ready = adv;

  f32ln_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(value_valid),
    .value_bits(value_bits), .is_last(is_last), .valid(v1), .q(s1)
  );

  f32ln_table #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_table (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v1), .din(s1), .valid(v2), .q(s2)
  );

  f32ln_mul u_mul (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v2), .din(s2), .valid(v3), .q(s3)
  );

  f32ln_add u_add (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v3), .din(s3), .valid(log_valid),
    .log_bits(log_bits), .end_of_array(end_of_array)
  );
endmodule
